// File: src/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared codes, widths and the command record passed from the front end,
// through the command queue, to the execution back end of the array list.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int DEPTH_MAX  = 1024;
	localparam int LEN_W      = $clog2(DEPTH_MAX + 1);
	localparam int IDX_W      = $clog2(DEPTH_MAX);
	localparam int DATA_W     = 32;
	localparam int OP_W       = 3;
	localparam int POS_W      = 7;
	localparam int ST_W       = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_GET    = 3'd2;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD     = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

	// Work left for the back end; K_REPLY needs no list access at all.
	typedef enum logic [2:0] {
		K_INSERT,
		K_DELETE,
		K_GET,
		K_LOCATE,
		K_REPLY
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ST_W-1:0]    status;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  value;
		logic [LEN_W-1:0]   len_before;
		logic [LEN_W-1:0]   len_after;
	} cmd_t;

endpackage

// File: src/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/pal_front.sv
// ----------------------------------------------------------------------------
// pal_front
// Command front end: checks each item against the running length, works out
// the status of items that need no list access and queues a command record.
// ----------------------------------------------------------------------------
module pal_front import pal_pkg::*; #(
	parameter int DEPTH = LIST_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OP_W-1:0]         op,
	input  logic [POS_W-1:0]        position,
	input  logic signed [DATA_W-1:0] value,
	input  logic                    q_full,
	output logic                    push,
	output cmd_t                    push_cmd,
	output logic                    busy
);

	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

	logic [LEN_W-1:0] count_q;
	logic [LEN_W-1:0] count_d;
	logic [LEN_W-1:0] pos_x;
	logic             pos_nz;
	logic             ins_ok;
	logic             rd_ok;

	assign busy   = q_full;
	assign push   = start && !q_full;
	assign pos_x  = LEN_W'(position);
	assign pos_nz = (position != '0);
	assign ins_ok = (count_q < DEPTH_L) && pos_nz && (pos_x <= count_q + LEN_W'(1));
	assign rd_ok  = pos_nz && (pos_x <= count_q);

	always_comb begin
		count_d             = count_q;
		push_cmd.kind       = K_REPLY;
		push_cmd.status     = ST_BAD;
		push_cmd.idx        = IDX_W'(position - POS_W'(1));
		push_cmd.value      = value;
		push_cmd.len_before = count_q;
		unique case (op)
			OP_INSERT: begin
				if (ins_ok) begin
					push_cmd.kind = K_INSERT;
					count_d       = count_q + LEN_W'(1);
				end
			end
			OP_DELETE: begin
				if (rd_ok) begin
					push_cmd.kind = K_DELETE;
					count_d       = count_q - LEN_W'(1);
				end
			end
			OP_GET: begin
				if (rd_ok) begin
					push_cmd.kind = K_GET;
				end
			end
			OP_LOCATE: begin
				push_cmd.kind = K_LOCATE;
			end
			OP_CLEAR: begin
				push_cmd.status = ST_OK;
				count_d         = '0;
			end
			default: begin
				push_cmd.status = ST_BAD;
			end
		endcase
		push_cmd.len_after = count_d;
	end

	// Track the length as seen after every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_d;
		end
	end

endmodule

// File: src/pal_queue.sv
// ----------------------------------------------------------------------------
// pal_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pal_queue import pal_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic valid,
	output logic full
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign head  = slot_q[rd_ptr_q];
	assign valid = (fill_q != 2'd0);
	assign full  = (fill_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: src/pal_back.sv
// ----------------------------------------------------------------------------
// pal_back
// Execution back end: runs one queued command at a time against the entry
// RAM, moving entries one per cycle on insert and delete, scanning on locate.
// ----------------------------------------------------------------------------
module pal_back import pal_pkg::*; #(
	parameter int DEPTH = LIST_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  cmd_t                     q_head,
	output logic                     pop,
	output logic                     done,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [POS_W-1:0]         found_position,
	output logic [POS_W-1:0]         list_length
);

	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_LAST,
		S_DEL,
		S_GET,
		S_LOC
	} state_t;

	state_t            state_q, state_d;
	cmd_t              cur_q, cur_d;
	logic [AW-1:0]     raddr_q, raddr_d;
	logic [AW-1:0]     last_addr;

	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] wdata, rdata;

	logic              res_v_d;
	logic [ST_W-1:0]   res_st_d;
	logic [DATA_W-1:0] res_rd_d;
	logic [POS_W-1:0]  res_found_d;
	logic [POS_W-1:0]  res_len_d;

	pal_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign last_addr = AW'(cur_q.len_before - LEN_W'(1));

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		raddr_d     = raddr_q;
		pop         = 1'b0;
		we          = 1'b0;
		waddr       = raddr_q;
		wdata       = rdata;
		re          = 1'b0;
		raddr       = raddr_q;
		res_v_d     = 1'b0;
		res_st_d    = ST_OK;
		res_rd_d    = '0;
		res_found_d = '0;
		res_len_d   = POS_W'(cur_q.len_after);
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					pop       = 1'b1;
					cur_d     = q_head;
					res_len_d = POS_W'(q_head.len_after);
					unique case (q_head.kind)
						K_INSERT: begin
							if (q_head.len_before == LEN_W'(q_head.idx)) begin
								// append at the end: nothing to move
								we      = 1'b1;
								waddr   = AW'(q_head.idx);
								wdata   = q_head.value;
								res_v_d = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = AW'(q_head.len_before - LEN_W'(1));
								raddr_d = raddr;
								state_d = S_INS;
							end
						end
						K_DELETE: begin
							if (LEN_W'(q_head.idx) + LEN_W'(1) == q_head.len_before) begin
								res_v_d = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = AW'(q_head.idx) + AW'(1);
								raddr_d = raddr;
								state_d = S_DEL;
							end
						end
						K_GET: begin
							re      = 1'b1;
							raddr   = AW'(q_head.idx);
							raddr_d = raddr;
							state_d = S_GET;
						end
						K_LOCATE: begin
							if (q_head.len_before == '0) begin
								res_v_d  = 1'b1;
								res_st_d = ST_MISSING;
							end else begin
								re      = 1'b1;
								raddr   = '0;
								raddr_d = '0;
								state_d = S_LOC;
							end
						end
						default: begin
							res_v_d  = 1'b1;
							res_st_d = q_head.status;
						end
					endcase
				end
			end
			S_INS: begin
				// move the entry just read up one place, read the next one down
				we    = 1'b1;
				waddr = raddr_q + AW'(1);
				if (raddr_q != AW'(cur_q.idx)) begin
					re      = 1'b1;
					raddr   = raddr_q - AW'(1);
					raddr_d = raddr;
				end else begin
					state_d = S_INS_LAST;
				end
			end
			S_INS_LAST: begin
				we      = 1'b1;
				waddr   = AW'(cur_q.idx);
				wdata   = cur_q.value;
				res_v_d = 1'b1;
				state_d = S_IDLE;
			end
			S_DEL: begin
				we    = 1'b1;
				waddr = raddr_q - AW'(1);
				if (raddr_q != last_addr) begin
					re      = 1'b1;
					raddr   = raddr_q + AW'(1);
					raddr_d = raddr;
				end else begin
					res_v_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GET: begin
				res_v_d  = 1'b1;
				res_rd_d = rdata;
				state_d  = S_IDLE;
			end
			S_LOC: begin
				if (rdata == cur_q.value) begin
					res_v_d     = 1'b1;
					res_found_d = POS_W'(LEN_W'(raddr_q) + LEN_W'(1));
					state_d     = S_IDLE;
				end else if (raddr_q == last_addr) begin
					res_v_d  = 1'b1;
					res_st_d = ST_MISSING;
					state_d  = S_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = raddr_q + AW'(1);
					raddr_d = raddr;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_v_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q   <= cur_d;
		raddr_q <= raddr_d;
		if (res_v_d) begin
			status         <= res_st_d;
			read_value     <= res_rd_d;
			found_position <= res_found_d;
			list_length    <= res_len_d;
		end
	end

endmodule

// File: src/positional_array_list.sv
// Throughput: one item at a time in the back end, one entry moved or compared per cycle
// (at most one RAM read and one RAM write each cycle); a two-item queue takes start meanwhile.
// Reset: arst_n clears the length and all control; entries hold until written; no stall on done.
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed words with 1-based positions: insert, delete, get,
// locate and clear, one status result per item.
// ----------------------------------------------------------------------------
module positional_array_list import pal_pkg::*; #(
	parameter int DEPTH = LIST_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [POS_W-1:0]         found_position,
	output logic [POS_W-1:0]         list_length
);

	logic push, pop, q_full, q_valid;
	cmd_t push_cmd, q_head;

	pal_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.position(position),
		.value   (value),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd),
		.busy    (busy)
	);

	pal_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (q_head),
		.valid   (q_valid),
		.full    (q_full)
	);

	pal_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.pop           (pop),
		.done          (done),
		.status        (status),
		.read_value    (read_value),
		.found_position(found_position),
		.list_length   (list_length)
	);

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("back end took a command from an empty queue");

	a_missing_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_MISSING |-> found_position == '0)
		else $error("missing value reported with a position");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> read_value == '0)
		else $error("failed item returned read data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_OK || status == ST_BAD || status == ST_MISSING)
		else $error("result status outside the defined codes");
`endif

endmodule

// File: dv/pal_result_checker.sv
// ----------------------------------------------------------------------------
// pal_result_checker
// Watches the command and result channels of the array list, keeps a shadow
// copy of the list to predict each reply, and compares replies in order.
// ----------------------------------------------------------------------------
module pal_result_checker import pal_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     done,
	input  logic [ST_W-1:0]          status,
	input  logic signed [DATA_W-1:0] read_value,
	input  logic [POS_W-1:0]         found_position,
	input  logic [POS_W-1:0]         list_length,
	output int                       fail_count,
	output int                       pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] read_value;
		logic [POS_W-1:0]  found_position;
		logic [POS_W-1:0]  list_length;
	} reply_t;

	logic [DATA_W-1:0] shadow_words [LIST_DEPTH];
	int                shadow_len = 0;
	reply_t            awaited_replies [$];
	reply_t            oldest;

	initial fail_count = 0;
	initial pending = 0;

	// Apply one operation to the shadow list and return the reply it earns.
	function automatic reply_t apply_list_op(input logic [OP_W-1:0] code,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] word);
		reply_t r;
		int     p;
		int     k;
		r = '0;
		r.status = ST_BAD;
		p = int'(pos);
		case (code)
			OP_INSERT: begin
				if (shadow_len < LIST_DEPTH && p >= 1 && p <= shadow_len + 1) begin
					for (k = shadow_len; k >= p; k--)
						shadow_words[k] = shadow_words[k-1];
					shadow_words[p-1] = word;
					shadow_len++;
					r.status = ST_OK;
				end
			end
			OP_DELETE: begin
				if (p >= 1 && p <= shadow_len) begin
					for (k = p - 1; k + 1 < shadow_len; k++)
						shadow_words[k] = shadow_words[k+1];
					shadow_len--;
					r.status = ST_OK;
				end
			end
			OP_GET: begin
				if (p >= 1 && p <= shadow_len) begin
					r.read_value = shadow_words[p-1];
					r.status = ST_OK;
				end
			end
			OP_LOCATE: begin
				r.status = ST_MISSING;
				for (k = 0; k < shadow_len; k++) begin
					if (shadow_words[k] == word) begin
						r.found_position = POS_W'(k + 1);
						r.status = ST_OK;
						break;
					end
				end
			end
			OP_CLEAR: begin
				shadow_len = 0;
				r.status = ST_OK;
			end
			default: ;
		endcase
		r.list_length = POS_W'(shadow_len);
		return r;
	endfunction

	function automatic void compare_field(input string name,
			input logic [DATA_W-1:0] want, input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = 0;
			awaited_replies.delete();
		end else begin
			if (done) begin
				if (awaited_replies.size() == 0) begin
					$error("reply with no item outstanding: status %0d", status);
					fail_count++;
				end else begin
					oldest = awaited_replies.pop_front();
					compare_field("status", DATA_W'(oldest.status), DATA_W'(status));
					compare_field("read_value", oldest.read_value, read_value);
					compare_field("found_position", DATA_W'(oldest.found_position),
						DATA_W'(found_position));
					compare_field("list_length", DATA_W'(oldest.list_length),
						DATA_W'(list_length));
				end
			end
			if (start && !busy)
				awaited_replies.push_back(apply_list_op(op, position, value));
		end
		pending = awaited_replies.size();
	end

endmodule

// File: dv/positional_array_list_tb.sv
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Drives directed corner items, then phases of list growth, shrinkage and
// mixed traffic with random idle gaps; the checker predicts every reply.
// ----------------------------------------------------------------------------
module positional_array_list_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pal_pkg::*;

	localparam int RANDOM_ITEMS = 930;
	localparam int QUIET_TAIL   = 150;
	localparam int PHASE_ITEMS  = 100;
	localparam int POOL_SIZE    = 12;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {GROW, SHRINK, MIXED} traffic_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [OP_W-1:0]          op = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     done;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0]         found_position;
	logic [POS_W-1:0]         list_length;

	int                fail_count;
	int                pending;
	int                cycle_count = 0;
	int                list_len = 0;
	logic [DATA_W-1:0] value_pool [POOL_SIZE];

	always #4 clk = ~clk;

	positional_array_list uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.read_value(read_value),
		.found_position(found_position),
		.list_length(list_length)
	);

	pal_result_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.read_value(read_value),
		.found_position(found_position),
		.list_length(list_length),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one item, hold it until taken, and track the list length.
	task automatic issue(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] word, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(3) == 0) begin
			gap = $urandom_range(4, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= code;
		position <= pos;
		value <= word;
		do @(posedge clk); while (busy);
		case (code)
			OP_INSERT: if (list_len < LIST_DEPTH && pos >= 1 && pos <= list_len + 1)
				list_len++;
			OP_DELETE: if (pos >= 1 && pos <= list_len)
				list_len--;
			OP_CLEAR: list_len = 0;
			default: ;
		endcase
	endtask

	// Mostly a legal position up to hi, now and then an illegal one.
	function automatic logic [POS_W-1:0] choose_pos(input int hi);
		if (hi < 1 || $urandom_range(9) == 0) begin
			if ($urandom_range(1) == 0)
				return '0;
			return POS_W'($urandom_range(127, hi + 1));
		end
		return POS_W'($urandom_range(hi, 1));
	endfunction

	task automatic issue_random(input traffic_t mode, input bit may_idle);
		int                w_ins;
		int                w_del;
		int                w_get;
		int                w_loc;
		int                roll;
		logic [DATA_W-1:0] word;
		case (mode)
			GROW: begin
				w_ins = 80; w_del = 4; w_get = 6; w_loc = 7;
			end
			SHRINK: begin
				w_ins = 8; w_del = 60; w_get = 14; w_loc = 15;
			end
			default: begin
				w_ins = 30; w_del = 25; w_get = 20; w_loc = 21;
			end
		endcase
		// Pool values make locate hits and duplicates common.
		word = ($urandom_range(3) != 0) ? value_pool[$urandom_range(POOL_SIZE - 1)]
			: $urandom;
		roll = $urandom_range(99);
		if (roll < w_ins)
			issue(OP_INSERT, choose_pos(list_len + 1), word, may_idle);
		else if (roll < w_ins + w_del)
			issue(OP_DELETE, choose_pos(list_len), word, may_idle);
		else if (roll < w_ins + w_del + w_get)
			issue(OP_GET, choose_pos(list_len), word, may_idle);
		else if (roll < w_ins + w_del + w_get + w_loc)
			issue(OP_LOCATE, POS_W'($urandom), word, may_idle);
		else if (roll < w_ins + w_del + w_get + w_loc + 1)
			issue(OP_CLEAR, POS_W'($urandom), word, may_idle);
		else
			issue(OP_W'($urandom_range(7, 5)), POS_W'($urandom), word, may_idle);
	endtask

	initial begin
		traffic_t mode;
		for (int i = 0; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: nothing to read, delete or find.
		issue(OP_GET, 7'd1, 32'h0, 1'b1);
		issue(OP_DELETE, 7'd1, 32'h0, 1'b1);
		issue(OP_LOCATE, 7'd0, 32'h0, 1'b1);
		issue(OP_INSERT, 7'd0, 32'h1, 1'b1);
		issue(OP_INSERT, 7'd2, 32'h1, 1'b1);
		// Build the list from both ends and the middle.
		issue(OP_INSERT, 7'd1, 32'h8000_0000, 1'b1);
		issue(OP_INSERT, 7'd2, 32'h7fff_ffff, 1'b1);
		issue(OP_INSERT, 7'd1, 32'hffff_ffff, 1'b1);
		issue(OP_INSERT, 7'd2, 32'h0000_0000, 1'b1);
		issue(OP_INSERT, 7'd6, 32'h5, 1'b1);
		issue(OP_INSERT, 7'd127, 32'h5, 1'b1);
		issue(OP_INSERT, 7'd5, 32'hffff_ffff, 1'b1);
		// Duplicate value: the lowest position must win.
		issue(OP_LOCATE, 7'd0, 32'hffff_ffff, 1'b1);
		issue(OP_LOCATE, 7'd3, 32'h7fff_ffff, 1'b1);
		issue(OP_LOCATE, 7'd0, 32'h1234_5678, 1'b1);
		issue(OP_GET, 7'd5, 32'h0, 1'b1);
		issue(OP_GET, 7'd6, 32'h0, 1'b1);
		issue(OP_GET, 7'd0, 32'h0, 1'b1);
		issue(OP_DELETE, 7'd2, 32'h0, 1'b1);
		issue(OP_DELETE, 7'd4, 32'h0, 1'b1);
		issue(OP_DELETE, 7'd1, 32'h0, 1'b1);
		// Unused op codes.
		issue(3'd5, 7'd1, 32'h0, 1'b1);
		issue(3'd6, 7'd127, 32'h7fff_ffff, 1'b1);
		issue(3'd7, 7'd64, 32'h8000_0000, 1'b1);
		issue(OP_CLEAR, 7'd0, 32'h0, 1'b1);

		// Start by growing so the full-list case comes early.
		mode = GROW;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n > 0 && n % PHASE_ITEMS == 0)
				mode = traffic_t'($urandom_range(2));
			issue_random(mode, n < RANDOM_ITEMS - QUIET_TAIL);
		end

		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/pal_pkg.sv
src/pal_ram.sv
src/pal_front.sv
src/pal_queue.sv
src/pal_back.sv
src/positional_array_list.sv
dv/pal_result_checker.sv
dv/positional_array_list_tb.sv
